/* rtl/core/u2j_pkg.sv */
// ----------------------------------------------------------------------------
// u2j_pkg
// Types, constants and helpers shared by the UTF-8 to JSON escape converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u2j_pkg;

  localparam int unsigned AccW     = 21;
  localparam int unsigned UnitW    = 16;
  localparam int unsigned IdxW     = 4;

  localparam logic [7:0]       ASCII_LIMIT  = 8'h80;
  localparam logic [7:0]       LEAD3_LIMIT  = 8'hE0;
  localparam logic [7:0]       LEAD4_LIMIT  = 8'hF0;
  localparam logic [7:0]       MASK_LEAD2   = 8'h1F;
  localparam logic [7:0]       MASK_LEAD3   = 8'h0F;
  localparam logic [7:0]       MASK_LEAD4   = 8'h07;
  localparam logic [7:0]       MASK_CONT    = 8'h3F;
  localparam logic [AccW-1:0]  BMP_MAX      = 21'h00FFFF;
  localparam logic [AccW-1:0]  SUPP_BASE    = 21'h010000;
  localparam logic [UnitW-1:0] HI_SURR_BASE = 16'hD800;
  localparam logic [UnitW-1:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [UnitW-1:0] SURR_LOW_MSK = 16'h03FF;

  localparam logic [6:0] CH_BSLASH = 7'h5C;
  localparam logic [6:0] CH_U      = 7'h75;
  localparam logic [6:0] CH_ZERO   = 7'h30;
  localparam logic [6:0] CH_A_OFS  = 7'h57;

  // Last character index of each job kind.
  localparam logic [IdxW-1:0] LAST_CHAR = 4'd0;
  localparam logic [IdxW-1:0] LAST_ESC  = 4'd5;
  localparam logic [IdxW-1:0] LAST_PAIR = 4'd11;
  localparam logic [IdxW-1:0] HALF_LEN  = 4'd6;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_byte;
    logic       run_last;
    logic       text_last;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_CHAR = 2'd0,
    JOB_ESC  = 2'd1,
    JOB_PAIR = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [UnitW-1:0] unit0;
    logic [UnitW-1:0] unit1;
    logic             eot;
  } job_t;

  typedef struct packed {
    logic has_out;
    logic idle;
  } dec_status_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] n7;
    n7 = {3'b000, nib};
    if (nib < 4'd10) begin
      hex_char = CH_ZERO + n7;
    end else begin
      hex_char = CH_A_OFS + n7;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/u2j_decode.sv */
// ----------------------------------------------------------------------------
// u2j_decode
// Tracks the UTF-8 sequence state and turns each byte that completes a character into an output job.
// ----------------------------------------------------------------------------
`default_nettype none

module u2j_decode
  import u2j_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  in_item_t         item,
  output job_t             job,
  output dec_status_t      status
);

  logic [1:0]      pend_r, pend_nxt;
  logic [AccW-1:0] acc_r, acc_nxt;
  logic [7:0]      b;
  logic [AccW-1:0] acc_new;
  logic [AccW-1:0] supp;
  logic [1:0]      pend_dec;

  always_comb begin
    b        = item.in_byte;
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    acc_new  = {acc_r[AccW-7:0], b[5:0] & MASK_CONT[5:0]};
    supp     = acc_new - SUPP_BASE;
    pend_dec = pend_r - 2'd1;
    job      = '0;
    status.has_out = 1'b0;

    if (pend_r == 2'd0) begin
      if (b < ASCII_LIMIT) begin
        status.has_out = 1'b1;
        job.kind  = JOB_CHAR;
        job.unit0 = {8'h00, b};
      end else if (b < LEAD3_LIMIT) begin
        pend_nxt = 2'd1;
        acc_nxt  = {13'd0, b & MASK_LEAD2};
      end else if (b < LEAD4_LIMIT) begin
        pend_nxt = 2'd2;
        acc_nxt  = {13'd0, b & MASK_LEAD3};
      end else begin
        pend_nxt = 2'd3;
        acc_nxt  = {13'd0, b & MASK_LEAD4};
      end
    end else begin
      pend_nxt = pend_dec;
      acc_nxt  = acc_new;
      if (pend_dec == 2'd0) begin
        status.has_out = 1'b1;
        acc_nxt        = '0;
        if (acc_new > BMP_MAX) begin
          job.kind  = JOB_PAIR;
          job.unit0 = HI_SURR_BASE + {5'd0, supp[AccW-1:10]};
          job.unit1 = LO_SURR_BASE | ({6'd0, supp[9:0]} & SURR_LOW_MSK);
        end else begin
          job.kind  = JOB_ESC;
          job.unit0 = acc_new[UnitW-1:0];
        end
      end
    end

    job.eot = item.end_of_text;
    if (item.end_of_text) begin
      pend_nxt = 2'd0;
      acc_nxt  = '0;
    end
    status.idle = (pend_r == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      acc_r  <= '0;
    end else if (fire) begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/u2j_emit.sv */
// ----------------------------------------------------------------------------
// u2j_emit
// Holds one output job and streams its characters into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module u2j_emit
  import u2j_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  job_t       job_in,
  output logic       slot_avail,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_data
);

  logic            job_valid_r;
  job_t            job_r;
  logic [IdxW-1:0] idx_r;
  logic            out_valid_r;
  out_item_t       out_data_r;

  logic             load;
  logic             is_last;
  logic [IdxW-1:0]  last_idx;
  logic             half;
  logic [IdxW-1:0]  pos_w;
  logic [UnitW-1:0] unit;
  logic [3:0]       nib;
  logic [6:0]       ch;

  always_comb begin
    case (job_r.kind)
      JOB_CHAR: last_idx = LAST_CHAR;
      JOB_ESC:  last_idx = LAST_ESC;
      JOB_PAIR: last_idx = LAST_PAIR;
      default:  last_idx = LAST_CHAR;
    endcase
    is_last = (idx_r == last_idx);
    half    = (idx_r >= HALF_LEN);
    pos_w   = half ? (idx_r - HALF_LEN) : idx_r;
    unit    = half ? job_r.unit1 : job_r.unit0;
    case (pos_w[2:0])
      3'd2:    nib = unit[15:12];
      3'd3:    nib = unit[11:8];
      3'd4:    nib = unit[7:4];
      default: nib = unit[3:0];
    endcase
    if (job_r.kind == JOB_CHAR) begin
      ch = job_r.unit0[6:0];
    end else if (pos_w[2:0] == 3'd0) begin
      ch = CH_BSLASH;
    end else if (pos_w[2:0] == 3'd1) begin
      ch = CH_U;
    end else begin
      ch = hex_char(nib);
    end
  end

  assign load       = job_valid_r && (!out_valid_r || out_ready);
  assign slot_avail = !job_valid_r || (load && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (push) begin
        job_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (load) begin
        if (is_last) begin
          job_valid_r <= 1'b0;
          idx_r       <= '0;
        end else begin
          idx_r <= idx_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      job_r <= job_in;
    end
    if (load) begin
      out_data_r.out_byte  <= ch;
      out_data_r.run_last  <= is_last;
      out_data_r.text_last <= is_last && job_r.eot;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/core/utf8_to_json_unicode_escape.sv */
// ----------------------------------------------------------------------------
// utf8_to_json_unicode_escape
// Converts a UTF-8 byte stream into ASCII with JSON \uXXXX escapes.
// ----------------------------------------------------------------------------
//   Channel  Ports                          Payload
//   input    in_valid / in_ready / in_data  in_item_t  (in_byte, end_of_text)
//   output   out_valid / out_ready / out_data  out_item_t (out_byte, flags)
//
// One output character leaves per cycle while out_ready is high: 1 for ASCII,
// 6 for an escape and 12 for a surrogate pair.
// Bytes that produce no output are taken every cycle; a byte that completes
// a character waits only while the single job slot of the serializer is busy.
// Reset (rst_n low, synchronous) clears the sequence state and empties the
// job slot and output register. Output stalls hold the current character.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_json_unicode_escape
  import u2j_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_data
);

  job_t        job;
  dec_status_t dec_status;
  logic        slot_avail;
  logic        in_fire;
  logic        push;

  assign in_ready = slot_avail || !dec_status.has_out;
  assign in_fire  = in_valid && in_ready;
  assign push     = in_fire && dec_status.has_out;

  u2j_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (in_fire),
    .item   (in_data),
    .job    (job),
    .status (dec_status)
  );

  u2j_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .job_in     (job),
    .slot_avail (slot_avail),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef NO_ASSERTIONS
  // A new job never lands on one that is still streaming.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> slot_avail)
    else $error("job slot overwritten");

  // The end of a text always closes the run of its byte.
  a_text_last_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.text_last) |-> out_data.run_last)
    else $error("text_last without run_last");

  // End of text leaves the decoder between sequences.
  a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.end_of_text) |=> dec_status.idle)
    else $error("sequence state survived end of text");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire
